/* rtl/gif_lzw_decoder_defines.svh */
// assertion macros for the gif lzw decoder
// used by the top level only; expects clk and rst_n in scope
`ifndef GIF_LZW_DECODER_DEFINES_SVH
`define GIF_LZW_DECODER_DEFINES_SVH

// same-cycle implication check
`define GIFL_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication check
`define GIFL_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gifl_pkg.sv */
// shared types, constants and helpers for the gif lzw decoder
// no dependencies
package gifl_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int NFC_W         = MAX_CODE_BITS + 1;
    localparam int TABLE_DEPTH   = 1 << MAX_CODE_BITS;
    localparam int BUF_W         = 24;
    localparam int BITS_W        = 5;
    localparam int CW_W          = 4;
    localparam int SYM_W         = 8;

    // opcodes
    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_PULL    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MORE    = 2'd1;
    localparam logic [1:0] ST_END     = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // result word sources
    localparam logic [2:0] RES_ZERO   = 3'd0;
    localparam logic [2:0] RES_PUSH   = 3'd1;
    localparam logic [2:0] RES_STATUS = 3'd2;
    localparam logic [2:0] RES_LIT    = 3'd3;
    localparam logic [2:0] RES_STACK  = 3'd4;

    typedef struct packed {
        logic       restart;
        logic       cfg_write;
        logic       push_byte;
        logic       pop_issue;
        logic       dict_reset;
        logic       consume;
        logic       set_ended;
        logic       decode_take;
        logic       walk_step;
        logic       lit_finish;
        logic       out_load;
        logic [2:0] res_sel;
        logic [1:0] res_status;
    } gifl_cmd_t;

    typedef struct packed {
        logic stack_empty;
        logic ended;
        logic bits_short;
        logic code_clear;
        logic code_eoi;
        logic code_invalid;
        logic lit_path;
        logic walk_more;
    } gifl_stat_t;

    // minimum code size limited to the legal range
    function automatic logic [CW_W-1:0] clamp_min(input logic [CW_W-1:0] v);
        logic [CW_W-1:0] r;
        begin
            r = v;
            if (v < CW_W'(2))
            begin
                r = CW_W'(2);
            end
            else if (v > CW_W'(8))
            begin
                r = CW_W'(8);
            end
            return r;
        end
    endfunction

endpackage

/* rtl/gif_lzw_decoder.sv */
// GIF LZW decoder. One word in gives one word out. A push is answered from idle, a
// pull served from the symbol stack via the pop state. A pull that reads a code ends
// in the decode state with no pixel (too few bits, end of information, invalid code),
// or yields one via the walk state, once per dictionary entry walked (one dictionary
// memory read per chain step), and the literal state; clear codes met are dropped in
// decode. A new word is taken once the previous result has been taken. The dictionary
// and stack memories need no clearing after reset.
// depends on gifl_pkg, gifl_ctrl, gifl_dpath and gif_lzw_decoder_defines.svh
`include "gif_lzw_decoder_defines.svh"
module gif_lzw_decoder
    import gifl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       opcode,
    input  logic [SYM_W-1:0] data_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [SYM_W-1:0] pixel_index,
    output logic             pixel_valid,
    output logic             byte_accepted,
    output logic [1:0]       status,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CW_W-1:0]  min_code_size
);

    gifl_cmd_t  cmd;
    gifl_stat_t stat;

    // sequencer
    gifl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    gifl_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .data_byte     (data_byte),
        .min_code_size (min_code_size),
        .pixel_index   (pixel_index),
        .pixel_valid   (pixel_valid),
        .byte_accepted (byte_accepted),
        .status        (status)
    );

    // checks
    `GIFL_CHECK(a_no_accept_while_held, in_valid && !in_stall, !out_valid, "word taken while result held")
    `GIFL_CHECK(a_cfg_in_exclusive, cfg_valid && cfg_ready, in_stall, "config write alongside a word")
    `GIFL_CHECK(a_pixel_ok, out_valid && pixel_valid, status == ST_OK && !byte_accepted, "pixel with bad status")
    `GIFL_CHECK_NEXT(a_push_one_cycle, in_valid && !in_stall && opcode == OP_PUSH, out_valid, "push result late")

endmodule

/* rtl/gifl_ctrl.sv */
// sequencing state machine for the gif lzw decoder
// depends on gifl_pkg; drives commands into gifl_dpath
module gifl_ctrl
    import gifl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    output logic       out_valid,
    input  logic       out_stall,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  gifl_stat_t stat,
    output gifl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_LIT    = 3'd3;
    localparam logic [2:0] S_POP    = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       idle_free;
    logic       in_fire;

    // handshakes
    assign idle_free = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = idle_free;
    assign in_stall  = !(idle_free && !cfg_valid);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.cfg_write = cfg_valid && cfg_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (opcode)
                        OP_PUSH:
                        begin
                            cmd.push_byte = 1'b1;
                            cmd.out_load  = 1'b1;
                            cmd.res_sel   = RES_PUSH;
                        end
                        OP_PULL:
                        begin
                            if (!stat.stack_empty)
                            begin
                                cmd.pop_issue = 1'b1;
                                state_next    = S_POP;
                            end
                            else if (stat.ended)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.res_sel    = RES_STATUS;
                                cmd.res_status = ST_END;
                            end
                            else
                            begin
                                state_next = S_DECODE;
                            end
                        end
                        OP_RESTART:
                        begin
                            cmd.restart  = 1'b1;
                            cmd.out_load = 1'b1;
                            cmd.res_sel  = RES_ZERO;
                        end
                        default:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.res_sel  = RES_ZERO;
                        end
                    endcase
                end
            end
            S_DECODE:
            begin
                if (stat.bits_short)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.res_sel    = RES_STATUS;
                    cmd.res_status = ST_MORE;
                    state_next     = S_IDLE;
                end
                else if (stat.code_clear)
                begin
                    cmd.consume    = 1'b1;
                    cmd.dict_reset = 1'b1;
                end
                else if (stat.code_eoi)
                begin
                    cmd.consume    = 1'b1;
                    cmd.set_ended  = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.res_sel    = RES_STATUS;
                    cmd.res_status = ST_END;
                    state_next     = S_IDLE;
                end
                else if (stat.code_invalid)
                begin
                    cmd.consume    = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.res_sel    = RES_STATUS;
                    cmd.res_status = ST_INVALID;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.consume     = 1'b1;
                    cmd.decode_take = 1'b1;
                    state_next      = stat.lit_path ? S_LIT : S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (!stat.walk_more)
                begin
                    state_next = S_LIT;
                end
            end
            S_LIT:
            begin
                cmd.lit_finish = 1'b1;
                cmd.out_load   = 1'b1;
                cmd.res_sel    = RES_LIT;
                state_next     = S_IDLE;
            end
            S_POP:
            begin
                cmd.out_load = 1'b1;
                cmd.res_sel  = RES_STACK;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result word holding flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/gifl_dpath.sv */
// datapath of the gif lzw decoder: bit buffer, dictionary, symbol stack
// depends on gifl_pkg; commanded by gifl_ctrl
module gifl_dpath
    import gifl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  gifl_cmd_t        cmd,
    output gifl_stat_t       stat,
    input  logic [SYM_W-1:0] data_byte,
    input  logic [CW_W-1:0]  min_code_size,
    output logic [SYM_W-1:0] pixel_index,
    output logic             pixel_valid,
    output logic             byte_accepted,
    output logic [1:0]       status
);

    localparam int DICT_W = CODE_W + SYM_W;

    // dictionary {prefix, suffix} and symbol stack
    logic [DICT_W-1:0] dict_mem [TABLE_DEPTH];
    logic [SYM_W-1:0]  stack_mem [TABLE_DEPTH];

    logic [CW_W-1:0]   min_reg, min_next;
    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [BITS_W-1:0] bits_reg, bits_next;
    logic [CW_W-1:0]   width_reg, width_next;
    logic [NFC_W-1:0]  nfc_reg, nfc_next;
    logic [CODE_W-1:0] prev_reg, prev_next;
    logic              prev_ok_reg, prev_ok_next;
    logic [SYM_W-1:0]  pfirst_reg, pfirst_next;
    logic              ended_reg, ended_next;
    logic [NFC_W-1:0]  depth_reg, depth_next;
    logic [CODE_W-1:0] c_reg, c_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              add_reg, add_next;

    logic [DICT_W-1:0] dict_rd_reg;
    logic [SYM_W-1:0]  stack_rd_reg;
    logic [SYM_W-1:0]  pix_reg;
    logic              pv_reg, acc_reg;
    logic [1:0]        st_reg;

    logic [CW_W-1:0]   eff_min, rst_min;
    logic [NFC_W-1:0]  clr, lit, rst_clr;
    logic [BUF_W-1:0]  code_mask;
    logic [CODE_W-1:0] code;
    logic [NFC_W-1:0]  code_x;
    logic              kwkwk;
    logic [CODE_W-1:0] c_pick;
    logic [CODE_W-1:0] rd_prefix;
    logic [SYM_W-1:0]  rd_suffix;
    logic              push_ok;
    logic              stk_we;
    logic [SYM_W-1:0]  stk_wdata;
    logic              stk_room;
    logic              dict_re;
    logic [CODE_W-1:0] dict_raddr;
    logic              dict_we;

    // code size derived values
    assign eff_min  = clamp_min(min_reg);
    assign clr      = NFC_W'(1) << eff_min;
    assign lit      = clr + NFC_W'(2);
    assign rst_min  = clamp_min(cmd.cfg_write ? min_code_size : min_reg);
    assign rst_clr  = NFC_W'(1) << rst_min;

    // code extraction, lsb first
    assign code_mask = (BUF_W'(1) << width_reg) - BUF_W'(1);
    assign code      = CODE_W'(buf_reg & code_mask);
    assign code_x    = {1'b0, code};
    assign kwkwk     = prev_ok_reg && (code_x == nfc_reg);
    assign c_pick    = kwkwk ? prev_reg : code;

    assign rd_prefix = dict_rd_reg[DICT_W-1:SYM_W];
    assign rd_suffix = dict_rd_reg[SYM_W-1:0];
    assign push_ok   = bits_reg <= BITS_W'(BUF_W - SYM_W);
    assign stk_room  = depth_reg < NFC_W'(TABLE_DEPTH);

    // status to the controller
    always_comb
    begin
        stat.stack_empty  = (depth_reg == '0);
        stat.ended        = ended_reg;
        stat.bits_short   = bits_reg < BITS_W'(width_reg);
        stat.code_clear   = (code_x == clr);
        stat.code_eoi     = (code_x == clr + NFC_W'(1));
        stat.code_invalid = prev_ok_reg ? (code_x > nfc_reg) : (code_x >= clr);
        stat.lit_path     = {1'b0, c_pick} < lit;
        stat.walk_more    = {1'b0, rd_prefix} >= lit;
    end

    // stack write source
    always_comb
    begin
        stk_we    = 1'b0;
        stk_wdata = pfirst_reg;
        if (cmd.decode_take && kwkwk)
        begin
            stk_we = stk_room;
        end
        else if (cmd.walk_step)
        begin
            stk_we    = stk_room;
            stk_wdata = rd_suffix;
        end
    end

    // dictionary access
    assign dict_re    = (cmd.decode_take && !stat.lit_path) || (cmd.walk_step && stat.walk_more);
    assign dict_raddr = cmd.walk_step ? rd_prefix : c_pick;
    assign dict_we    = cmd.lit_finish && add_reg && (nfc_reg < NFC_W'(TABLE_DEPTH));

    // next state of the decoder registers
    always_comb
    begin
        min_next     = min_reg;
        buf_next     = buf_reg;
        bits_next    = bits_reg;
        width_next   = width_reg;
        nfc_next     = nfc_reg;
        prev_next    = prev_reg;
        prev_ok_next = prev_ok_reg;
        pfirst_next  = pfirst_reg;
        ended_next   = ended_reg;
        depth_next   = depth_reg;
        c_next       = c_reg;
        code_next    = code_reg;
        add_next     = add_reg;

        if (cmd.cfg_write || cmd.restart)
        begin
            if (cmd.cfg_write)
            begin
                min_next = min_code_size;
            end
            buf_next     = '0;
            bits_next    = '0;
            ended_next   = 1'b0;
            depth_next   = '0;
            width_next   = rst_min + CW_W'(1);
            nfc_next     = rst_clr + NFC_W'(2);
            prev_ok_next = 1'b0;
            prev_next    = '0;
        end
        else
        begin
            // byte into the bit buffer
            if (cmd.push_byte && push_ok)
            begin
                buf_next  = buf_reg | (BUF_W'(data_byte) << bits_reg);
                bits_next = bits_reg + BITS_W'(SYM_W);
            end
            // drop one code
            if (cmd.consume)
            begin
                buf_next  = buf_reg >> width_reg;
                bits_next = bits_reg - BITS_W'(width_reg);
            end
            if (cmd.dict_reset)
            begin
                width_next   = eff_min + CW_W'(1);
                nfc_next     = lit;
                prev_ok_next = 1'b0;
                prev_next    = '0;
            end
            if (cmd.set_ended)
            begin
                ended_next = 1'b1;
            end
            if (cmd.pop_issue)
            begin
                depth_next = depth_reg - NFC_W'(1);
            end
            if (stk_we)
            begin
                depth_next = depth_reg + NFC_W'(1);
            end
            if (cmd.decode_take)
            begin
                c_next    = c_pick;
                code_next = code;
                add_next  = prev_ok_reg;
            end
            if (cmd.walk_step)
            begin
                c_next = rd_prefix;
            end
            // close the string: new entry and new previous code
            if (cmd.lit_finish)
            begin
                if (dict_we)
                begin
                    nfc_next = nfc_reg + NFC_W'(1);
                    if ((nfc_reg + NFC_W'(1)) == (NFC_W'(1) << width_reg)
                        && width_reg < CW_W'(MAX_CODE_BITS))
                    begin
                        width_next = width_reg + CW_W'(1);
                    end
                end
                prev_next    = code_reg;
                prev_ok_next = 1'b1;
                pfirst_next  = c_reg[SYM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg     <= CW_W'(2);
            buf_reg     <= '0;
            bits_reg    <= '0;
            width_reg   <= CW_W'(3);
            nfc_reg     <= NFC_W'(6);
            prev_reg    <= '0;
            prev_ok_reg <= 1'b0;
            ended_reg   <= 1'b0;
            depth_reg   <= '0;
        end
        else
        begin
            min_reg     <= min_next;
            buf_reg     <= buf_next;
            bits_reg    <= bits_next;
            width_reg   <= width_next;
            nfc_reg     <= nfc_next;
            prev_reg    <= prev_next;
            prev_ok_reg <= prev_ok_next;
            ended_reg   <= ended_next;
            depth_reg   <= depth_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pfirst_reg <= pfirst_next;
        c_reg      <= c_next;
        code_reg   <= code_next;
        add_reg    <= add_next;
    end

    // dictionary memory
    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            dict_mem[nfc_reg[CODE_W-1:0]] <= {prev_reg, c_reg[SYM_W-1:0]};
        end
        if (dict_re)
        begin
            dict_rd_reg <= dict_mem[dict_raddr];
        end
    end

    // symbol stack memory
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[depth_reg[CODE_W-1:0]] <= stk_wdata;
        end
        if (cmd.pop_issue)
        begin
            stack_rd_reg <= stack_mem[depth_next[CODE_W-1:0]];
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.res_sel)
                RES_PUSH:
                begin
                    pix_reg <= '0;
                    pv_reg  <= 1'b0;
                    acc_reg <= push_ok;
                    st_reg  <= ended_reg ? ST_END : ST_OK;
                end
                RES_STATUS:
                begin
                    pix_reg <= '0;
                    pv_reg  <= 1'b0;
                    acc_reg <= 1'b0;
                    st_reg  <= cmd.res_status;
                end
                RES_LIT:
                begin
                    pix_reg <= c_reg[SYM_W-1:0];
                    pv_reg  <= 1'b1;
                    acc_reg <= 1'b0;
                    st_reg  <= ST_OK;
                end
                RES_STACK:
                begin
                    pix_reg <= stack_rd_reg;
                    pv_reg  <= 1'b1;
                    acc_reg <= 1'b0;
                    st_reg  <= ST_OK;
                end
                default:
                begin
                    pix_reg <= '0;
                    pv_reg  <= 1'b0;
                    acc_reg <= 1'b0;
                    st_reg  <= ST_OK;
                end
            endcase
        end
    end

    assign pixel_index   = pix_reg;
    assign pixel_valid   = pv_reg;
    assign byte_accepted = acc_reg;
    assign status        = st_reg;

endmodule

/* tb/sv/gif_lzw_decoder_tb.sv */
// self-checking testbench for the gif lzw decoder: directed table, then lzw streams
// built by an on-the-fly encoder, with noise, restarts and minimum code size changes
// depends on gifl_pkg and the gif_lzw_decoder rtl
module gif_lzw_decoder_tb
    import gifl_pkg::*;
();

    typedef struct packed {
        logic [7:0] pix;
        logic       pix_ok;
        logic       acc;
        logic [1:0] st;
    } pixel_word_t;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  b;
        bit          typed;
        pixel_word_t want;
    } stim_row_t;

    localparam int CYCLE_LIMIT = 600000;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [1:0]       opcode;
    logic [SYM_W-1:0] data_byte;
    logic             out_valid;
    logic             out_stall;
    logic [SYM_W-1:0] pixel_index;
    logic             pixel_valid;
    logic             byte_accepted;
    logic [1:0]       status;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CW_W-1:0]  min_code_size;

    gif_lzw_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_index   (pixel_index),
        .pixel_valid   (pixel_valid),
        .byte_accepted (byte_accepted),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .min_code_size (min_code_size)
    );

    // decoder shadow state
    int unsigned sh_min;
    logic [11:0] sh_prefix [TABLE_DEPTH];
    logic [7:0]  sh_suffix [TABLE_DEPTH];
    logic [7:0]  sh_first  [TABLE_DEPTH];
    logic [7:0]  sh_stack  [TABLE_DEPTH];
    int unsigned sh_depth, sh_buf, sh_bits, sh_width, sh_free, sh_prev;
    bit          sh_prev_ok, sh_ended;

    pixel_word_t pending_words [$];
    int unsigned words_sent, words_checked, errors, cycles, pixels_seen, images_sent;
    int unsigned rx_cycles;

    // encoder state
    int          enc_dict [int];
    int unsigned enc_next, enc_acc, enc_nacc, enc_w, enc_dfree;
    bit          enc_dfirst;
    logic [7:0]  stream_bytes [$];

    function automatic int unsigned eff_min();
        if (sh_min < 2) return 2;
        if (sh_min > 8) return 8;
        return sh_min;
    endfunction

    function automatic void dict_restart();
        sh_width   = eff_min() + 1;
        sh_free    = (1 << eff_min()) + 2;
        sh_prev_ok = 0;
        sh_prev    = 0;
    endfunction

    function automatic void decoder_restart();
        sh_depth = 0;
        sh_buf   = 0;
        sh_bits  = 0;
        sh_ended = 0;
        dict_restart();
    endfunction

    function automatic int unsigned first_sym(int unsigned c);
        if (c < (1 << eff_min())) return c;
        return sh_first[c % TABLE_DEPTH];
    endfunction

    function automatic void stack_sym(int unsigned s);
        if (sh_depth < TABLE_DEPTH)
        begin
            sh_stack[sh_depth] = s[7:0];
            sh_depth++;
        end
    endfunction

    // string of a code onto the stack, last symbol first
    function automatic void unwind(int unsigned c);
        int unsigned steps;
        steps = 0;
        while (c >= (1 << eff_min()) + 2 && steps < TABLE_DEPTH)
        begin
            c = c % TABLE_DEPTH;
            stack_sym(sh_suffix[c]);
            c = sh_prefix[c];
            steps++;
        end
        stack_sym(c & 8'hFF);
    endfunction

    function automatic logic [1:0] take_code();
        int unsigned clr, code, fs, e;
        clr = 1 << eff_min();
        forever
        begin
            if (sh_bits < sh_width) return ST_MORE;
            code = sh_buf & ((1 << sh_width) - 1);
            sh_buf  = sh_buf >> sh_width;
            sh_bits = sh_bits - sh_width;
            if (code == clr)
            begin
                dict_restart();
                continue;
            end
            if (code == clr + 1)
            begin
                sh_ended = 1;
                return ST_END;
            end
            if (!sh_prev_ok)
            begin
                if (code >= clr) return ST_INVALID;
                stack_sym(code);
                sh_prev    = code;
                sh_prev_ok = 1;
                return ST_OK;
            end
            if (code < sh_free)
            begin
                fs = first_sym(code);
                unwind(code);
            end
            else if (code == sh_free)
            begin
                fs = first_sym(sh_prev);
                stack_sym(fs);
                unwind(sh_prev);
            end
            else
            begin
                return ST_INVALID;
            end
            if (sh_free < TABLE_DEPTH)
            begin
                e = sh_free;
                sh_prefix[e] = sh_prev[11:0];
                sh_suffix[e] = fs[7:0];
                sh_first[e]  = 8'(first_sym(sh_prev));
                sh_free++;
                if (sh_free == (1 << sh_width) && sh_width < MAX_CODE_BITS) sh_width++;
            end
            sh_prev = code;
            return ST_OK;
        end
    endfunction

    function automatic pixel_word_t decode_word(logic [1:0] op, logic [7:0] b);
        pixel_word_t w;
        w = '0;
        if (op == OP_PUSH)
        begin
            if (sh_bits + 8 <= BUF_W)
            begin
                sh_buf  = sh_buf | (int'(b) << sh_bits);
                sh_bits = sh_bits + 8;
                w.acc   = 1;
            end
            w.st = sh_ended ? ST_END : ST_OK;
        end
        else if (op == OP_PULL)
        begin
            if (sh_depth == 0) w.st = sh_ended ? ST_END : take_code();
            if (w.st == ST_OK && sh_depth > 0)
            begin
                sh_depth--;
                w.pix    = sh_stack[sh_depth];
                w.pix_ok = 1;
            end
        end
        else if (op == OP_RESTART)
        begin
            decoder_restart();
        end
        return w;
    endfunction

    // clock and cycle limit
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("gif_lzw_decoder_tb: FAIL");
            $finish;
        end
    end

    // result word checker
    always @(posedge clk)
    begin
        pixel_word_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{pixel_index, pixel_valid, byte_accepted, status};
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word %p", $time, got);
                errors++;
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                if (got.pix_ok) pixels_seen++;
                if (got.pix !== want.pix || got.pix_ok !== want.pix_ok)
                begin
                    $display("%0t: pixel expected %0d/%0b got %0d/%0b", $time,
                             want.pix, want.pix_ok, got.pix, got.pix_ok);
                    errors++;
                end
                if (got.acc !== want.acc)
                begin
                    $display("%0t: byte_accepted expected %0b got %0b", $time,
                             want.acc, got.acc);
                    errors++;
                end
                if (got.st !== want.st)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.st, got.st);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off counted here
    always @(posedge clk or negedge rst_n)
    begin
        int hold;
        int unsigned mode;
        if (!rst_n)
        begin
            out_stall <= 0;
            rx_cycles <= 0;
        end
        else
        begin
            rx_cycles <= rx_cycles + 1;
            mode = (rx_cycles / 700) % 4;
            hold = (rx_cycles >= 1500 && rx_cycles < 1900);
            if (hold) out_stall <= 1;
            else if (mode == 0) out_stall <= 0;
            else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
            else if (mode == 2) out_stall <= ($urandom_range(0, 1) == 0);
            else out_stall <= (rx_cycles % 5 < 2);
        end
    end

    // sender: bursts of random length with gaps
    int unsigned burst_left;

    task automatic send_word(logic [1:0] op, logic [7:0] b, bit typed = 0,
                             pixel_word_t typed_want = '0);
        pixel_word_t w;
        int gap;
        opcode    <= op;
        data_byte <= b;
        in_valid  <= 1;
        do @(posedge clk); while (in_stall);
        w = decode_word(op, b);
        pending_words.push_back(typed ? typed_want : w);
        words_sent++;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                       : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending_words.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_min(logic [3:0] v);
        cfg_valid     <= 1;
        min_code_size <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        sh_min = v;
        decoder_restart();
        @(posedge clk);
    endtask

    // lzw encoder, code widths track the decoder's
    task automatic put_code(int unsigned code);
        enc_acc  = enc_acc | (code << enc_nacc);
        enc_nacc = enc_nacc + enc_w;
        while (enc_nacc >= 8)
        begin
            stream_bytes.push_back(enc_acc[7:0]);
            enc_acc  = enc_acc >> 8;
            enc_nacc = enc_nacc - 8;
        end
    endtask

    task automatic put_clear();
        enc_w = eff_min() + 1;
        put_code(1 << eff_min());
        enc_dict.delete();
        enc_next   = (1 << eff_min()) + 2;
        enc_dfree  = enc_next;
        enc_dfirst = 1;
    endtask

    task automatic put_data(int unsigned code);
        put_code(code);
        if (enc_dfirst) enc_dfirst = 0;
        else if (enc_dfree < TABLE_DEPTH)
        begin
            enc_dfree++;
            if (enc_dfree == (1 << enc_w) && enc_w < MAX_CODE_BITS) enc_w++;
        end
    endtask

    task automatic build_stream(int unsigned npix, int unsigned alpha, bit mid_clear,
                                bit truncate);
        int unsigned cur, k, key, i;
        stream_bytes.delete();
        enc_acc  = 0;
        enc_nacc = 0;
        put_clear();
        cur = $urandom_range(0, alpha - 1);
        for (i = 1; i < npix; i++)
        begin
            k   = $urandom_range(0, alpha - 1);
            key = cur * 256 + k;
            if (enc_dict.exists(key))
            begin
                cur = enc_dict[key];
            end
            else
            begin
                put_data(cur);
                if (mid_clear && i == npix / 2)
                begin
                    put_clear();
                end
                else if (enc_next < TABLE_DEPTH)
                begin
                    enc_dict[key] = enc_next;
                    enc_next++;
                end
                cur = k;
            end
        end
        put_data(cur);
        if (!truncate) put_code((1 << eff_min()) + 1);
        if (enc_nacc > 0) stream_bytes.push_back(enc_acc[7:0]);
        if (truncate && stream_bytes.size() > 1) void'(stream_bytes.pop_back());
    endtask

    // feed one stream, pushing at random while bytes fit and pulling otherwise
    task automatic play_stream(bit noisy);
        int unsigned idx;
        idx = 0;
        forever
        begin
            if (sh_ended && sh_depth == 0)
            begin
                send_word(OP_PULL, 8'h00);
                break;
            end
            if (idx >= stream_bytes.size() && sh_depth == 0 && sh_bits < sh_width) break;
            if (noisy && $urandom_range(0, 9) == 0)
                send_word(2'($urandom_range(0, 3)), 8'($urandom));
            else if (idx < stream_bytes.size() && sh_bits + 8 <= BUF_W &&
                     $urandom_range(0, 2) != 0)
            begin
                send_word(OP_PUSH, stream_bytes[idx]);
                idx++;
            end
            else
            begin
                send_word(OP_PULL, 8'($urandom));
            end
        end
        send_word(OP_RESTART, 8'($urandom));
        images_sent++;
    endtask

    // directed rows: typed results only where obvious
    stim_row_t rows [] = '{
        '{OP_PULL,    8'h00, 1, '{8'd0, 1'b0, 1'b0, ST_MORE}},
        '{2'd3,       8'hFF, 1, '{8'd0, 1'b0, 1'b0, ST_OK}},
        '{OP_PUSH,    8'h00, 1, '{8'd0, 1'b0, 1'b1, ST_OK}},
        '{OP_PUSH,    8'hFF, 1, '{8'd0, 1'b0, 1'b1, ST_OK}},
        '{OP_PUSH,    8'h55, 1, '{8'd0, 1'b0, 1'b1, ST_OK}},
        '{OP_PUSH,    8'hAA, 1, '{8'd0, 1'b0, 1'b0, ST_OK}},
        '{OP_PULL,    8'h00, 0, '0},
        '{OP_PULL,    8'h00, 0, '0},
        '{OP_PULL,    8'h00, 0, '0},
        '{OP_PULL,    8'h00, 0, '0},
        '{OP_PULL,    8'h00, 0, '0},
        '{OP_PULL,    8'h00, 0, '0},
        '{OP_PULL,    8'h00, 0, '0},
        '{OP_PULL,    8'h00, 0, '0},
        '{OP_RESTART, 8'h00, 1, '{8'd0, 1'b0, 1'b0, ST_OK}},
        '{OP_PUSH,    8'h07, 0, '0},
        '{OP_PULL,    8'h00, 1, '{8'd0, 1'b0, 1'b0, ST_INVALID}},
        '{OP_RESTART, 8'hFF, 1, '{8'd0, 1'b0, 1'b0, ST_OK}},
        '{OP_PUSH,    8'h05, 1, '{8'd0, 1'b0, 1'b1, ST_OK}},
        '{OP_PULL,    8'h00, 1, '{8'd0, 1'b0, 1'b0, ST_END}},
        '{OP_PULL,    8'h00, 1, '{8'd0, 1'b0, 1'b0, ST_END}},
        '{OP_PUSH,    8'h12, 1, '{8'd0, 1'b0, 1'b1, ST_END}},
        '{OP_RESTART, 8'h00, 1, '{8'd0, 1'b0, 1'b0, ST_OK}}
    };

    // main sequence
    initial
    begin
        logic [3:0] sizes [] = '{4'd2, 4'd8, 4'd0, 4'd5, 4'd15, 4'd3, 4'd7, 4'd1, 4'd4,
                                 4'd9, 4'd6, 4'd8, 4'd2};
        int unsigned phase, alpha, npix;
        rst_n         = 0;
        in_valid      = 0;
        opcode        = OP_PUSH;
        data_byte     = 0;
        cfg_valid     = 0;
        min_code_size = 4'd2;
        cycles        = 0;
        errors        = 0;
        burst_left    = 0;
        sh_min        = 2;
        decoder_restart();
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (rows[i]) send_word(rows[i].op, rows[i].b, rows[i].typed, rows[i].want);

        phase = 0;
        while (words_sent < 1700)
        begin
            drain();
            write_min(sizes[phase % sizes.size()]);
            phase++;
            repeat (3)
            begin
                alpha = $urandom_range(1, 1 << eff_min());
                npix  = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
                build_stream(npix, alpha, $urandom_range(0, 3) == 0,
                             $urandom_range(0, 9) == 0);
                play_stream($urandom_range(0, 4) == 0);
            end
        end
        drain();
        repeat (20) @(posedge clk);
        if (pending_words.size() > 0) errors++;

        $display("covered %0d words (%0d pixels) over %0d streams and %0d code sizes",
                 words_checked, pixels_seen, images_sent, phase);
        if (errors == 0)
        begin
            $display("gif_lzw_decoder_tb: PASS");
        end
        else
        begin
            $display("gif_lzw_decoder_tb: FAIL");
        end
        $finish;
    end

endmodule
